FILE: src/ihs_pkg.sv
// Shared types, widths and constants for the RGB to IHS pixel unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ihs_pkg;

    // Number of vectoring CORDIC cells; legal range 8 to 24.
    localparam int CORDIC_STAGES = 16;

    // Sample and product widths (8-bit samples).
    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = SAMPLE_W + 2;       // r+g+b
    localparam int DIFF_W   = SAMPLE_W + 3;       // 2b-r-g, g-r (signed)
    localparam int COEF_W   = 16;
    localparam int MUL_W    = DIFF_W + COEF_W + 1;
    localparam int PROD_W   = 25;                 // |PU|, |PV| < 2^24
    localparam int MAG_W    = PROD_W - 1;
    localparam int IPROD_W  = SUM_W + COEF_W;
    localparam int AC_W     = MAG_W - 2;
    localparam int SQ_W     = 2 * AC_W;
    localparam int RAD_W    = SQ_W + 1;

    // Square root chain: one result bit per cell.
    localparam int SQRT_CELLS = (RAD_W + 1) / 2;
    localparam int RAD_PAD_W  = 2 * SQRT_CELLS;
    localparam int ROOT_W     = SQRT_CELLS;
    localparam int REM_W      = ROOT_W + 2;

    // CORDIC datapath.
    localparam int CW           = PROD_W + 2;
    localparam int ZW           = 28;
    localparam int ATAN_W       = 24;
    localparam int ATAN_ENTRIES = 24;
    localparam int SHIFT_W      = $clog2(ATAN_ENTRIES);

    // Output fields.
    localparam int INTEN_W = 15;
    localparam int UV_W    = 15;
    localparam int HUE_W   = 16;
    localparam int SAT_W   = 14;

    // Pipeline depths.
    localparam int SIDE_LEN   = SQRT_CELLS + 2;
    localparam int HUE_DLY    = SQRT_CELLS + 2 - CORDIC_STAGES;
    localparam int RESULT_LAT = SQRT_CELLS + 5;

    // Q16 coefficients.
    localparam logic [COEF_W-1:0] COEF_I = 16'd37837;
    localparam logic [COEF_W-1:0] COEF_U = 16'd26755;
    localparam logic [COEF_W-1:0] COEF_V = 16'd46341;

    // Angle constants.
    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW:0]   TWO_PI_Q24  = 29'sd105414357;
    localparam logic [HUE_W-1:0]     HALF_PI_Q13 = 16'd12868;
    localparam logic [HUE_W-1:0]     TH_PI_Q13   = 16'd38604;
    localparam logic [HUE_W+1:0]     TWO_PI_Q13  = 18'd51472;
    localparam logic [SAT_W-1:0]     SAT_MAX     = 14'd16383;

    typedef logic [SHIFT_W-1:0] t_shift;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [RAD_PAD_W-1:0] rad;
        logic [REM_W-1:0]     rem;
        logic [ROOT_W-1:0]    root;
    } t_sqrt;

    typedef struct packed {
        logic [INTEN_W-1:0]     inten;
        logic signed [UV_W-1:0] u;
        logic signed [UV_W-1:0] v;
        logic                   spec;
        logic [HUE_W-1:0]       spec_hue;
    } t_side;

    // Q24 arctangent of 2^-i.
    function automatic logic [ATAN_W-1:0] atan_q24(input t_shift idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 24'd13176795;
            5'd1:    val = 24'd7778716;
            5'd2:    val = 24'd4110060;
            5'd3:    val = 24'd2086331;
            5'd4:    val = 24'd1047214;
            5'd5:    val = 24'd524117;
            5'd6:    val = 24'd262123;
            5'd7:    val = 24'd131069;
            5'd8:    val = 24'd65536;
            5'd9:    val = 24'd32768;
            5'd10:   val = 24'd16384;
            5'd11:   val = 24'd8192;
            5'd12:   val = 24'd4096;
            5'd13:   val = 24'd2048;
            5'd14:   val = 24'd1024;
            5'd15:   val = 24'd512;
            5'd16:   val = 24'd256;
            5'd17:   val = 24'd128;
            5'd18:   val = 24'd64;
            5'd19:   val = 24'd32;
            5'd20:   val = 24'd16;
            5'd21:   val = 24'd8;
            5'd22:   val = 24'd4;
            5'd23:   val = 24'd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: src/ihs_front.sv
// Front end: coefficient products, rounding of I/U/V, CORDIC pre-rotation.
// Depends on ihs_pkg.
`default_nettype none

module ihs_front
    import ihs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_acc,
    input  wire logic [SAMPLE_W-1:0] i_red,
    input  wire logic [SAMPLE_W-1:0] i_green,
    input  wire logic [SAMPLE_W-1:0] i_blue,
    output logic                     o_vld,
    output t_side                    o_side,
    output t_cordic                  o_cordic,
    output logic [AC_W-1:0]          o_mag_a,
    output logic [AC_W-1:0]          o_mag_c
);

    logic signed [DIFF_W-1:0] d_u, d_v;
    logic [SUM_W-1:0]         isum;
    logic signed [MUL_W-1:0]  mul_u, mul_v;
    logic [IPROD_W-1:0]       mul_i;

    logic                     r_vld1;
    logic signed [PROD_W-1:0] r_pu, r_pv;
    logic [IPROD_W-1:0]       r_iprod;

    logic signed [PROD_W-1:0] neg_pu, neg_pv;
    logic [MAG_W-1:0]         mag_u, mag_v;
    logic [MAG_W:0]           rsum_u, rsum_v;
    logic [UV_W-1:0]          rnd_u, rnd_v;
    logic [IPROD_W-1:0]       rsum_i;
    logic                     pu_zero, pv_zero, pu_neg, pv_neg;
    t_side                    n_side;
    t_cordic                  n_cordic;

    // Stage 1: products.
    always_comb begin
        d_u = $signed({2'b00, i_blue, 1'b0}) - $signed({3'b000, i_red})
            - $signed({3'b000, i_green});
        d_v = $signed({3'b000, i_green}) - $signed({3'b000, i_red});
        isum = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
        mul_u = d_u * $signed({1'b0, COEF_U});
        mul_v = d_v * $signed({1'b0, COEF_V});
        mul_i = IPROD_W'(isum) * IPROD_W'(COEF_I);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pu    <= mul_u[PROD_W-1:0];
        r_pv    <= mul_v[PROD_W-1:0];
        r_iprod <= mul_i;
    end

    // Stage 2: round to Q6, take magnitudes, set up the CORDIC vector.
    always_comb begin
        pu_neg  = r_pu[PROD_W-1];
        pv_neg  = r_pv[PROD_W-1];
        pu_zero = (r_pu == '0);
        pv_zero = (r_pv == '0);
        neg_pu  = -r_pu;
        neg_pv  = -r_pv;
        mag_u   = pu_neg ? neg_pu[MAG_W-1:0] : r_pu[MAG_W-1:0];
        mag_v   = pv_neg ? neg_pv[MAG_W-1:0] : r_pv[MAG_W-1:0];
        rsum_u  = {1'b0, mag_u} + (MAG_W+1)'(512);
        rsum_v  = {1'b0, mag_v} + (MAG_W+1)'(512);
        rnd_u   = rsum_u[MAG_W:10];
        rnd_v   = rsum_v[MAG_W:10];
        rsum_i  = r_iprod + IPROD_W'(512);

        n_side.inten = rsum_i[INTEN_W+9:10];
        n_side.u     = pu_neg ? $signed(UV_W'(0) - rnd_u) : $signed(rnd_u);
        n_side.v     = pv_neg ? $signed(UV_W'(0) - rnd_v) : $signed(rnd_v);
        // U zero: hue comes from the sign of V alone, no CORDIC.
        n_side.spec  = pu_zero;
        if (pv_zero) begin
            n_side.spec_hue = '0;
        end else if (pv_neg) begin
            n_side.spec_hue = TH_PI_Q13;
        end else begin
            n_side.spec_hue = HALF_PI_Q13;
        end

        // Left half-plane: turn the vector by pi first.
        if (pu_neg) begin
            n_cordic.x = {{(CW-PROD_W){neg_pu[PROD_W-1]}}, neg_pu};
            n_cordic.y = {{(CW-PROD_W){neg_pv[PROD_W-1]}}, neg_pv};
            n_cordic.z = PI_Q24;
        end else begin
            n_cordic.x = {{(CW-PROD_W){r_pu[PROD_W-1]}}, r_pu};
            n_cordic.y = {{(CW-PROD_W){r_pv[PROD_W-1]}}, r_pv};
            n_cordic.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_side   <= n_side;
        o_cordic <= n_cordic;
        o_mag_a  <= mag_u[MAG_W-1:2];
        o_mag_c  <= mag_v[MAG_W-1:2];
    end

endmodule

`default_nettype wire

FILE: src/ihs_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on ihs_pkg (types and arctangent table).
`default_nettype none

module ihs_cordic_cell
    import ihs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_shift  i_shift,
    input  wire t_cordic i_in,
    output t_cordic      o_out
);

    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    logic                 y_pos;
    t_cordic              n_out;

    always_comb begin
        xs    = $signed(i_in.x) >>> i_shift;
        ys    = $signed(i_in.y) >>> i_shift;
        ang   = $signed({{(ZW-ATAN_W){1'b0}}, atan_q24(i_shift)});
        y_pos = !i_in.y[CW-1] && (i_in.y != '0);
        // Rotate toward the x axis.
        if (y_pos) begin
            n_out.x = i_in.x + ys;
            n_out.y = i_in.y - xs;
            n_out.z = i_in.z + ang;
        end else begin
            n_out.x = i_in.x - ys;
            n_out.y = i_in.y + xs;
            n_out.z = i_in.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        o_out <= n_out;
    end

endmodule

`default_nettype wire

FILE: src/ihs_sqrt_cell.sv
// One digit of a restoring integer square root, registered.
// Depends on ihs_pkg.
`default_nettype none

module ihs_sqrt_cell
    import ihs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire t_sqrt i_in,
    output t_sqrt      o_out
);

    logic [REM_W+1:0] acc, trial, diff;
    t_sqrt            n_out;

    always_comb begin
        acc   = {i_in.rem, i_in.rad[RAD_PAD_W-1 -: 2]};
        trial = {2'b00, i_in.root, 2'b01};
        diff  = acc - trial;
        n_out.rad = {i_in.rad[RAD_PAD_W-3:0], 2'b00};
        if (acc >= trial) begin
            n_out.rem  = diff[REM_W-1:0];
            n_out.root = {i_in.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_out.rem  = acc[REM_W-1:0];
            n_out.root = {i_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        o_out <= n_out;
    end

endmodule

`default_nettype wire

FILE: src/rgb_to_ihs_pixel_unit.sv
// Top level of the RGB to intensity/hue/saturation pixel unit.
// Depends on ihs_pkg, ihs_front, ihs_cordic_cell and ihs_sqrt_cell.
//
// Usage:
//   Input: a pixel (i_red, i_green, i_blue) is taken at each rising edge
//   where start is high and busy is low. busy is low whenever reset is
//   released, so a pixel may be offered in every clock.
//   Output: each pixel gives one item: intensity, Taylor U/V, hue and
//   saturation, shown for exactly one cycle with o_strobe high. There is
//   no back-pressure; the receiver must take every item as it comes.
//   Configuration: i_cfg_data (taylor_only) is written when i_cfg_valid
//   and o_cfg_ready are both high. Write it only while no pixel is in
//   flight. In Taylor-only mode hue and saturation come out as 0.
//   Timing: one pixel per clock sustained. The delay from a taken pixel to
//   its item is set by the 23-cell square root chain for saturation (one
//   root bit per cell) plus the product, rounding and squaring stages. The
//   CORDIC chain for hue is shorter and its result is held in a delay line
//   to line up.
//   Reset: synchronous, active low; it flushes all items in flight and
//   clears taylor_only to 0.
`default_nettype none

module rgb_to_ihs_pixel_unit
    import ihs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [SAMPLE_W-1:0] i_red,
    input  wire logic [SAMPLE_W-1:0] i_green,
    input  wire logic [SAMPLE_W-1:0] i_blue,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data,
    output logic                     o_strobe,
    output logic [INTEN_W-1:0]       o_intensity,
    output logic signed [UV_W-1:0]   o_coord_u,
    output logic signed [UV_W-1:0]   o_coord_v,
    output logic [HUE_W-1:0]         o_hue,
    output logic [SAT_W-1:0]         o_saturation
);

    logic               accept;
    logic               r_taylor_only;

    logic               front_vld;
    t_side              front_side;
    t_cordic            front_cordic;
    logic [AC_W-1:0]    front_a, front_c;

    logic [SQ_W-1:0]    r_sq_a, r_sq_c;
    t_sqrt              r_rad_in;

    t_cordic            cordic_bus [CORDIC_STAGES+1];
    t_sqrt              sqrt_bus   [SQRT_CELLS+1];

    logic               r_vld  [SIDE_LEN];
    t_side              r_side [SIDE_LEN];
    logic [HUE_W-1:0]   r_hue  [HUE_DLY];

    logic signed [ZW:0] zx, zw;
    logic [ZW:0]        zr;
    logic [HUE_W-1:0]   n_hue;
    logic [ROOT_W:0]    sat_sum;
    logic [SAT_W-1:0]   sat_val;
    t_side              side_last;

    logic [INTEN_W-1:0] n_out_inten;
    logic [UV_W-1:0]    n_out_u, n_out_v;
    logic [HUE_W-1:0]   n_out_hue;
    logic [SAT_W-1:0]   n_out_sat;

    // A pixel with start high is taken in every cycle outside reset.
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taylor_only <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_taylor_only <= i_cfg_data;
        end
    end

    // Products, rounding and CORDIC setup (two stages).
    ihs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (accept),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .o_vld    (front_vld),
        .o_side   (front_side),
        .o_cordic (front_cordic),
        .o_mag_a  (front_a),
        .o_mag_c  (front_c)
    );

    // Squares, then their sum as the radicand for the root chain.
    always_ff @(posedge i_clk) begin
        r_sq_a        <= SQ_W'(front_a) * SQ_W'(front_a);
        r_sq_c        <= SQ_W'(front_c) * SQ_W'(front_c);
        r_rad_in.rad  <= RAD_PAD_W'(r_sq_a) + RAD_PAD_W'(r_sq_c);
        r_rad_in.rem  <= '0;
        r_rad_in.root <= '0;
    end

    // CORDIC row: cell k applies the micro-rotation by atan(2^-k).
    assign cordic_bus[0] = front_cordic;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        ihs_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (SHIFT_W'(k)),
            .i_in    (cordic_bus[k]),
            .o_out   (cordic_bus[k+1])
        );
    end

    // Square root row: each cell settles one root bit, top bit first.
    assign sqrt_bus[0] = r_rad_in;

    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        ihs_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_in  (sqrt_bus[j]),
            .o_out (sqrt_bus[j+1])
        );
    end

    // Hue from the final angle: wrap negatives by 2*pi, round Q24 to Q13,
    // and fold a full turn back to zero.
    always_comb begin
        zx = {cordic_bus[CORDIC_STAGES].z[ZW-1], cordic_bus[CORDIC_STAGES].z};
        zw = zx[ZW] ? (zx + TWO_PI_Q24) : zx;
        zr = zw[ZW] ? '0 : ($unsigned(zw) + (ZW+1)'(1024));
        if (zr[ZW:11] >= TWO_PI_Q13) begin
            n_hue = '0;
        end else begin
            n_hue = zr[HUE_W+10:11];
        end
    end

    // Hue delay line: line the CORDIC result up with the root chain.
    always_ff @(posedge i_clk) begin
        r_hue[0] <= n_hue;
        for (int i = 1; i < HUE_DLY; i++) begin
            r_hue[i] <= r_hue[i-1];
        end
    end

    // Side line: carry valid, I/U/V and the special-case hue to the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE_LEN; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= front_vld;
            for (int i = 1; i < SIDE_LEN; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= front_side;
        for (int i = 1; i < SIDE_LEN; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Output stage: round and clamp the root, pick hue, zero both in Taylor mode.
    always_comb begin
        side_last = r_side[SIDE_LEN-1];
        sat_sum   = {1'b0, sqrt_bus[SQRT_CELLS].root} + (ROOT_W+1)'(128);
        if (sat_sum[ROOT_W:8] > (ROOT_W-7)'(SAT_MAX)) begin
            sat_val = SAT_MAX;
        end else begin
            sat_val = sat_sum[SAT_W+7:8];
        end
        n_out_inten = side_last.inten;
        n_out_u     = side_last.u;
        n_out_v     = side_last.v;
        if (r_taylor_only) begin
            n_out_hue = '0;
            n_out_sat = '0;
        end else begin
            n_out_hue = side_last.spec ? side_last.spec_hue : r_hue[HUE_DLY-1];
            n_out_sat = sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vld[SIDE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_intensity  <= n_out_inten;
        o_coord_u    <= n_out_u;
        o_coord_v    <= n_out_v;
        o_hue        <= n_out_hue;
        o_saturation <= n_out_sat;
    end

endmodule

`default_nettype wire

FILE: src/ihs_checker.sv
// Port-level checks for rgb_to_ihs_pixel_unit, attached by bind.
// Depends on ihs_pkg (result latency and field widths).
`default_nettype none

module ihs_checker
    import ihs_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_strobe,
    input wire logic signed [UV_W-1:0] o_coord_u,
    input wire logic signed [UV_W-1:0] o_coord_v,
    input wire logic [HUE_W-1:0]    o_hue,
    input wire logic [SAT_W-1:0]    o_saturation
);

    // Every taken pixel yields an item after the fixed latency.
    a_item_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##RESULT_LAT o_strobe)
        else $error("taken pixel gave no item");

    // No item without a pixel taken at the matching edge.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, RESULT_LAT))
        else $error("item without a pixel");

    // Hue stays below a full turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hue < HUE_W'(TWO_PI_Q13)))
        else $error("hue out of range");

    // Zero chroma gives zero hue; nonzero hue implies nonzero saturation.
    a_zero_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_coord_u == '0) && (o_coord_v == '0)) |-> (o_hue == '0))
        else $error("hue nonzero at zero chroma");

    a_hue_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_hue != '0)) |-> (o_saturation != '0))
        else $error("hue without saturation");

endmodule

bind rgb_to_ihs_pixel_unit ihs_checker u_ihs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_coord_u    (o_coord_u),
    .o_coord_v    (o_coord_v),
    .o_hue        (o_hue),
    .o_saturation (o_saturation)
);

`default_nettype wire

FILE: tb/sv/ihs_pixel_checker.sv
`timescale 1ns / 1ps
// Scoreboard for rgb_to_ihs_pixel_unit: computes the IHS item of every accepted pixel
// and compares it with what the block emits. Depends on ihs_pkg for field widths.

module ihs_pixel_checker
    import ihs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [SAMPLE_W-1:0] i_red,
    input  logic [SAMPLE_W-1:0] i_green,
    input  logic [SAMPLE_W-1:0] i_blue,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_data,
    input  logic                i_strobe,
    input  logic [INTEN_W-1:0]  i_intensity,
    input  logic [UV_W-1:0]     i_coord_u,
    input  logic [UV_W-1:0]     i_coord_v,
    input  logic [HUE_W-1:0]    i_hue,
    input  logic [SAT_W-1:0]    i_saturation,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam longint Q16_INTEN   = 37837;
    localparam longint Q16_U       = 26755;
    localparam longint Q16_V       = 46341;
    localparam longint ANGLE_PI    = 52707179;
    localparam longint ANGLE_2PI   = 105414357;
    localparam longint HUE_QUARTER = 12868;
    localparam longint HUE_3QUARTR = 38604;
    localparam longint HUE_TURN    = 51472;
    localparam int     ARCTAN_ROWS = 24;

    typedef struct packed {
        logic [INTEN_W-1:0] inten;
        logic [UV_W-1:0]    u;
        logic [UV_W-1:0]    v;
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   sat;
    } t_ihs_px;

    t_ihs_px ihs_expected[$];
    logic    taylor_mode;

    function automatic longint arctan_row(input int k);
        case (k)
            0:  return 13176795;
            1:  return 7778716;
            2:  return 4110060;
            3:  return 2086331;
            4:  return 1047214;
            5:  return 524117;
            6:  return 262123;
            7:  return 131069;
            default: return longint'(65536) >>> (k - 8);
        endcase
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root, bitv, rest;
        root = 0;
        rest = n;
        bitv = 64'd1 << 62;
        while (bitv > rest) bitv >>= 2;
        while (bitv != 0) begin
            if (rest >= root + bitv) begin
                rest = rest - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Q16 product to Q6, ties away from zero, saturated to the field.
    function automatic longint q16_to_q6(input longint p);
        longint m, r;
        m = (p < 0) ? -p : p;
        r = (m + 512) >>> 10;
        if (p < 0) r = -r;
        if (r < -16384) r = -16384;
        if (r > 16383) r = 16383;
        return r;
    endfunction

    // Vectoring CORDIC on the Q16 coordinates, angle in Q24, hue in Q13.
    function automatic longint cordic_hue(input longint pu, input longint pv);
        longint x, y, z, xs, ys, h;
        if (pu == 0 && pv == 0) return 0;
        if (pu == 0) return (pv > 0) ? HUE_QUARTER : HUE_3QUARTR;
        x = pu;
        y = pv;
        z = 0;
        // fold the left half plane over by pi
        if (x < 0) begin
            x = -x;
            y = -y;
            z = ANGLE_PI;
        end
        for (int k = 0; k < CORDIC_STAGES && k < ARCTAN_ROWS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_row(k);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_row(k);
            end
        end
        if (z < 0) z = z + ANGLE_2PI;
        if (z < 0) z = 0;
        h = (z + 1024) >>> 11;
        if (h >= HUE_TURN) h = 0;
        return h;
    endfunction

    function automatic t_ihs_px ihs_of_pixel(input int r, input int g, input int b,
                                             input logic taylor);
        t_ihs_px px;
        longint  pu, pv, inten, u, v, hue;
        longint unsigned a, c, sat;
        pu    = longint'(2 * b - r - g) * Q16_U;
        pv    = longint'(g - r) * Q16_V;
        inten = (longint'(r + g + b) * Q16_INTEN + 512) >>> 10;
        if (inten > 32767) inten = 32767;
        u   = q16_to_q6(pu);
        v   = q16_to_q6(pv);
        hue = 0;
        sat = 0;
        if (!taylor) begin
            a   = longint'((pu < 0) ? -pu : pu) >> 2;
            c   = longint'((pv < 0) ? -pv : pv) >> 2;
            sat = (floor_sqrt(a * a + c * c) + 128) >> 8;
            if (sat > 16383) sat = 16383;
            hue = cordic_hue(pu, pv);
        end
        px.inten = inten[INTEN_W-1:0];
        px.u     = u[UV_W-1:0];
        px.v     = v[UV_W-1:0];
        px.hue   = hue[HUE_W-1:0];
        px.sat   = sat[SAT_W-1:0];
        return px;
    endfunction

    function automatic int field_mismatch(input t_ihs_px want);
        int bad;
        bad = 0;
        if (i_intensity !== want.inten) begin
            $error("intensity: expected %0d, got %0d", want.inten, i_intensity);
            bad++;
        end
        if (i_coord_u !== want.u) begin
            $error("coord_u: expected %0d, got %0d", $signed(want.u), $signed(i_coord_u));
            bad++;
        end
        if (i_coord_v !== want.v) begin
            $error("coord_v: expected %0d, got %0d", $signed(want.v), $signed(i_coord_v));
            bad++;
        end
        if (i_hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, i_hue);
            bad++;
        end
        if (i_saturation !== want.sat) begin
            $error("saturation: expected %0d, got %0d", want.sat, i_saturation);
            bad++;
        end
        return bad;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            taylor_mode = 1'b0;
            ihs_expected.delete();
        end else begin
            if (i_strobe) begin
                if (ihs_expected.size() == 0) begin
                    $error("result item with no pixel waiting for it");
                    o_fail_count++;
                end else if (field_mismatch(ihs_expected.pop_front()) != 0) begin
                    o_fail_count++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) taylor_mode = i_cfg_data;
            if (i_start && !i_busy)
                ihs_expected.push_back(ihs_of_pixel(i_red, i_green, i_blue, taylor_mode));
        end
        o_pending = ihs_expected.size();
    end

endmodule

FILE: tb/sv/rgb_to_ihs_pixel_unit_tb.sv
`timescale 1ns / 1ps
// Top of the rgb_to_ihs_pixel_unit testbench: clock, reset, pixel and register stimulus.
// Depends on ihs_pkg, rgb_to_ihs_pixel_unit and ihs_pixel_checker.

module rgb_to_ihs_pixel_unit_tb;
    import ihs_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    // Pipeline depth plus margin; used to settle before register writes and at the end.
    localparam int SETTLE_CYCLES = RESULT_LAT + 8;

    // Random pixel families: gray pixels hit zero chroma, equal red/green hit V = 0,
    // 2b = r + g hits U = 0, corners exercise the field extremes.
    typedef enum int {PX_GRAY, PX_V_ZERO, PX_U_ZERO, PX_CORNER, PX_UNIFORM} t_px_family;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [SAMPLE_W-1:0] i_red;
    logic [SAMPLE_W-1:0] i_green;
    logic [SAMPLE_W-1:0] i_blue;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_data;
    logic                o_strobe;
    logic [INTEN_W-1:0]  o_intensity;
    logic [UV_W-1:0]     o_coord_u;
    logic [UV_W-1:0]     o_coord_v;
    logic [HUE_W-1:0]    o_hue;
    logic [SAT_W-1:0]    o_saturation;

    int fail_count;
    int pending;
    bit gaps_on;

    rgb_to_ihs_pixel_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_intensity  (o_intensity),
        .o_coord_u    (o_coord_u),
        .o_coord_v    (o_coord_v),
        .o_hue        (o_hue),
        .o_saturation (o_saturation)
    );

    ihs_pixel_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_strobe     (o_strobe),
        .i_intensity  (o_intensity),
        .i_coord_u    (o_coord_u),
        .i_coord_v    (o_coord_v),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every item behind the longest idle gap).
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one pixel and hold it until the block takes it. With gaps on, sometimes drop start
    // for a random burst first and scramble the samples meanwhile; the block must ignore them.
    task automatic send_pixel(input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
                              input logic [SAMPLE_W-1:0] b);
        int gap;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap     = $urandom_range(1, 15);
            start   = 1'b0;
            i_red   = $urandom;
            i_green = $urandom;
            i_blue  = $urandom;
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_red   = r;
        i_green = g;
        i_blue  = b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Write taylor_only only with the pipeline empty: drain, settle, then handshake.
    task automatic write_taylor_mode(input logic mode);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Hand-picked pixels: extremes, zero chroma, U = 0 on both sides, hue near a full
    // turn and near zero, and each quadrant of the (U, V) plane.
    task automatic send_probe_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd0,   8'd254, 8'd127);
        send_pixel(8'd254, 8'd0,   8'd127);
        send_pixel(8'd1,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd85,  8'd170, 8'd0);
        send_pixel(8'd128, 8'd64,  8'd200);
        send_pixel(8'd170, 8'd85,  8'd85);
        send_pixel(8'd85,  8'd170, 8'd170);
    endtask

    task automatic send_random_pixels(input int count);
        logic [SAMPLE_W-1:0] r, g, b;
        logic [SAMPLE_W:0]   rg_sum;
        t_px_family          family;
        int                  pick;
        repeat (count) begin
            pick   = $urandom_range(0, 9);
            family = (pick < 6) ? PX_UNIFORM : t_px_family'(pick - 6);
            r = $urandom;
            g = $urandom;
            b = $urandom;
            case (family)
                PX_GRAY: begin
                    g = r;
                    b = r;
                end
                PX_V_ZERO: begin
                    g = r;
                end
                PX_U_ZERO: begin
                    g[0]   = r[0];
                    rg_sum = {1'b0, r} + {1'b0, g};
                    b      = rg_sum[SAMPLE_W:1];
                end
                PX_CORNER: begin
                    r = {SAMPLE_W{r[0]}};
                    g = {SAMPLE_W{g[0]}};
                    b = $urandom_range(0, 1) ? {SAMPLE_W{b[0]}} : b;
                end
                default: begin
                end
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        gaps_on     = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full IHS mode: probes back to back, then random pixels with idle bursts.
        write_taylor_mode(1'b0);
        send_probe_pixels();
        gaps_on = 1'b1;
        send_random_pixels(200);

        // Taylor-only mode: hue and saturation must read zero.
        write_taylor_mode(1'b1);
        gaps_on = 1'b0;
        send_probe_pixels();
        gaps_on = 1'b1;
        send_random_pixels(120);

        write_taylor_mode(1'b0);
        send_random_pixels(120);

        write_taylor_mode(1'b1);
        gaps_on = 1'b0;
        send_random_pixels(60);

        // Last stretch at full rate, no idling.
        write_taylor_mode(1'b0);
        send_random_pixels(100);

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/ihs_pkg.sv
src/ihs_front.sv
src/ihs_cordic_cell.sv
src/ihs_sqrt_cell.sv
src/rgb_to_ihs_pixel_unit.sv
src/ihs_checker.sv
tb/sv/ihs_pixel_checker.sv
tb/sv/rgb_to_ihs_pixel_unit_tb.sv
